@@ hw/rtl/bdc_pkg.sv @@
package bdc_pkg;

   localparam int TICK_BITS      = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [COUNT_BITS-1:0] DEFAULT_PERIOD = 16'd8;
   localparam logic [COUNT_BITS-1:0] DEFAULT_WINDOW = 16'h10;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_PERIOD     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DOUBLE_CLICK_WINDOW = 4'd1;

   typedef enum logic [0:0] {
      ACT_SAMPLE = 1'b0,
      ACT_READ   = 1'b1
   } action_type;

   // The pin is active low.
   localparam logic PIN_PRESSED = 1'b0;

   typedef struct packed {
      logic [COUNT_BITS-1:0] debounce_period;
      logic [COUNT_BITS-1:0] double_click_window;
   } cfg_type;

   typedef struct packed {
      action_type           action;
      logic                 pin_level;
      logic [TICK_BITS-1:0] tick_now;
   } item_type;

   typedef struct packed {
      logic pressed;
      logic dbl_click;
   } result_type;

endpackage

@@ hw/rtl/bdc_csr.sv @@
module bdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [bdc_pkg::CSR_INDEX_BITS-1:0]  wr_index,
   input  logic [bdc_pkg::CSR_DATA_BITS-1:0]   wr_data,
   output bdc_pkg::cfg_type                    cfg
);

   bdc_pkg::cfg_type cfg_ff;
   bdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            bdc_pkg::REG_DEBOUNCE_PERIOD:     cfg_in.debounce_period     = wr_data;
            bdc_pkg::REG_DOUBLE_CLICK_WINDOW: cfg_in.double_click_window = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_period     <= bdc_pkg::DEFAULT_PERIOD;
         cfg_ff.double_click_window <= bdc_pkg::DEFAULT_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/bdc_debounce.sv @@
module bdc_debounce (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bdc_pkg::item_type      item,
   input  bdc_pkg::cfg_type       cfg,
   output bdc_pkg::result_type    result
);

   logic [bdc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                           pressed_ff, pressed_in;
   logic                           double_ff, double_in;
   logic [bdc_pkg::TICK_BITS-1:0]  last_tick_ff, last_tick_in;
   logic [bdc_pkg::TICK_BITS-1:0]  limit;
   logic                           dbl_out;

   // The window end wraps at the tick width and is compared without regard to wrap.
   assign limit = last_tick_ff
                + {{(bdc_pkg::TICK_BITS-bdc_pkg::COUNT_BITS){1'b0}}, cfg.double_click_window};

   always_comb begin
      count_in     = count_ff;
      pressed_in   = pressed_ff;
      double_in    = double_ff;
      last_tick_in = last_tick_ff;
      dbl_out      = double_ff;
      if (step) begin
         unique case (item.action)
            bdc_pkg::ACT_READ: begin
               double_in = 1'b0;
            end
            bdc_pkg::ACT_SAMPLE: begin
               if (item.pin_level == bdc_pkg::PIN_PRESSED) begin
                  // A count above the period can be left behind by a lowered period.
                  if (count_ff >= cfg.debounce_period) begin
                     count_in   = cfg.debounce_period;
                     pressed_in = 1'b1;
                     if (!pressed_ff) begin
                        double_in    = (item.tick_now < limit);
                        last_tick_in = item.tick_now;
                     end
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  if (count_ff == '0) begin
                     pressed_in = 1'b0;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
               dbl_out = double_in;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pressed_ff   <= 1'b0;
         double_ff    <= 1'b0;
         last_tick_ff <= '0;
      end else begin
         count_ff     <= count_in;
         pressed_ff   <= pressed_in;
         double_ff    <= double_in;
         last_tick_ff <= last_tick_in;
      end
   end

   assign result.pressed   = pressed_in;
   assign result.dbl_click = dbl_out;

   a_press_needs_pressed_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(pressed_ff) |-> $past(step) && $past(item.action) == bdc_pkg::ACT_SAMPLE
                            && $past(item.pin_level) == bdc_pkg::PIN_PRESSED)
      else $error("pressed flag set without a pressed sample");

   a_count_only_on_sample: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !($past(step) && $past(item.action) == bdc_pkg::ACT_SAMPLE)
      |-> $stable(count_ff))
      else $error("level count moved without a sample item");

   a_read_clears_double: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(step) && $past(item.action) == bdc_pkg::ACT_READ
      |-> !double_ff)
      else $error("double-click flag not cleared by read");

   a_tick_only_on_press: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$rose(pressed_ff) |-> $stable(last_tick_ff))
      else $error("press tick stored without a new press");

endmodule

@@ hw/rtl/button_debounce_double_click.sv @@
// Integrating debouncer for an active-low button with double-click detection.
// Items pass through an input register and a result register with the
// debounce state updated in between, so one item is taken every cycle
// while the result side does not stall; its result is presented from the
// result register and is taken when the result side does not stall. A
// sample item (action 0) steps the level counter; a read item (action 1)
// returns the double-click flag and clears it. Configuration writes are
// always ready and should be made while no items are in flight.
module button_debounce_double_click (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic                                req_pin_level,
   input  logic [bdc_pkg::TICK_BITS-1:0]       req_tick_now,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pressed,
   output logic                                rsp_double_click,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   bdc_pkg::item_type     in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   bdc_pkg::result_type   out_ff, out_in;
   bdc_pkg::cfg_type      cfg;
   bdc_pkg::result_type   result;
   logic                  advance;
   logic                  req_take;

   // The held item moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in        = 1'b1;
         in_item_in.action  = bdc_pkg::action_type'(req_action);
         in_item_in.pin_level = req_pin_level;
         in_item_in.tick_now  = req_tick_now;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

   bdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   bdc_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_pressed      = out_ff.pressed;
   assign rsp_double_click = out_ff.dbl_click;

endmodule
